>>> rtl/x86_insn_length_decoder_macros.svh
// assertion helpers shared by the rtl
`ifndef X86_INSN_LENGTH_DECODER_MACROS_SVH
`define X86_INSN_LENGTH_DECODER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define XILD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define XILD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/xild_pkg.sv
`default_nettype none

package xild_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 4;
	localparam int TOTAL_W = 5;
	localparam int IMM_W   = 3;
	localparam int CFG_W   = 4;

	localparam logic [LEN_W-1:0]   MAX_INSN_LEN   = 4'd15;
	localparam logic [CFG_W-1:0]   MIN_COVER_RST  = 4'd5;
	localparam logic [TOTAL_W-1:0] TOTAL_SAT      = 5'd31;

	localparam logic [BYTE_W-1:0] OP_ESC     = 8'h0F;
	localparam logic [BYTE_W-1:0] OP2_SKIP1  = 8'h1E;
	localparam logic [BYTE_W-1:0] OP2_MODRM  = 8'h1F;

	localparam logic [1:0] MOD_NODISP = 2'd0;
	localparam logic [1:0] MOD_DISP8  = 2'd1;
	localparam logic [1:0] MOD_REG    = 2'd3;
	localparam logic [2:0] RM_SIB     = 3'd4;
	localparam logic [2:0] RM_DISP32  = 3'd5;

	typedef enum logic [4:0] {
		PH_OPC   = 5'b00001,
		PH_OP2   = 5'b00010,
		PH_MODRM = 5'b00100,
		PH_SIB   = 5'b01000,
		PH_SKIP  = 5'b10000
	} phase_t;

	typedef enum logic [2:0] {
		OC_BAD,
		OC_DONE,
		OC_IMM,
		OC_MODRM,
		OC_ESC
	} opc_class_t;

	typedef struct packed {
		opc_class_t        cls;
		logic [IMM_W-1:0]  imm;
	} opc_info_t;

	function automatic logic is_prefix(input logic [BYTE_W-1:0] b);
		return b == 8'h66 || b == 8'h67 || b == 8'hF2 || b == 8'hF3 ||
			b == 8'h2E || b == 8'h3E || b == 8'h26 || b == 8'h36 ||
			b == 8'h64 || b == 8'h65;
	endfunction

	// one-byte opcode table: class and trailing immediate size
	function automatic opc_info_t classify(input logic [BYTE_W-1:0] op);
		opc_info_t r;
		r.cls = OC_BAD;
		r.imm = 3'd0;
		unique case (op) inside
			[8'h50:8'h5F], 8'h90, 8'hC9, 8'h98, 8'h99, 8'hF8, 8'hFC:
				r.cls = OC_DONE;
			8'h6A, 8'hEB, [8'hB0:8'hB7]: begin
				r.cls = OC_IMM;
				r.imm = 3'd1;
			end
			8'h68, 8'hE8, 8'hE9, [8'hB8:8'hBF]: begin
				r.cls = OC_IMM;
				r.imm = 3'd4;
			end
			8'h83, 8'hC6: begin
				r.cls = OC_MODRM;
				r.imm = 3'd1;
			end
			8'h81, 8'hC7: begin
				r.cls = OC_MODRM;
				r.imm = 3'd4;
			end
			8'h89, 8'h8B, 8'h01, 8'h03, 8'h29, 8'h2B, 8'h31, 8'h33,
			8'h39, 8'h3B, 8'h09, 8'h0B, 8'h21, 8'h23, 8'h85, 8'h8D,
			8'h87, 8'hFF, 8'h88, 8'h8A:
				r.cls = OC_MODRM;
			OP_ESC:
				r.cls = OC_ESC;
			default:
				r.cls = OC_BAD;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/xild_code_if.sv
`default_nettype none

interface xild_code_if;
	logic                        valid;
	logic                        ready;
	logic [xild_pkg::BYTE_W-1:0] code_byte;
	logic                        scan_start;

	modport source (output valid, code_byte, scan_start, input ready);
	modport sink   (input valid, code_byte, scan_start, output ready);
endinterface

`default_nettype wire

>>> rtl/xild_result_if.sv
`default_nettype none

interface xild_result_if;
	logic                         valid;
	logic                         ready;
	logic [xild_pkg::LEN_W-1:0]   insn_length;
	logic [xild_pkg::TOTAL_W-1:0] total_length;
	logic                         scan_complete;
	logic                         unsupported;

	modport source (output valid, insn_length, total_length, scan_complete, unsupported,
		input ready);
	modport sink   (input valid, insn_length, total_length, scan_complete, unsupported,
		output ready);
endinterface

`default_nettype wire

>>> rtl/x86_insn_length_decoder.sv
// Streaming length decoder for 32-bit x86 code. One code byte enters per word on the
// code channel and the block takes a byte every cycle while the result side keeps up.
// An accepted byte is held in the input register while the decode logic works on it;
// its word (if it ends an instruction) is loaded into the result register when the
// decode stage advances and is presented from there. A word waiting on the result
// channel holds the decode stage and, once the input register is full, the code channel.
// The per-byte decode state lives in the decode stage and is updated for each byte that
// advances, which is what sets the one-byte-per-cycle rate. A word with scan_start set
// begins a new scan; bytes after the scan ends (complete or unsupported) and bytes before
// the first scan_start are dropped without a result. min_cover_bytes is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, which the block
// itself does not enforce. It resets to 5.
`default_nettype none

`include "x86_insn_length_decoder_macros.svh"

module x86_insn_length_decoder (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [xild_pkg::CFG_W-1:0] cfg_wdata,
	xild_code_if.sink                      code,
	xild_result_if.source                  result
);

	import xild_pkg::*;

	// configuration
	logic [CFG_W-1:0] min_cover_q;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              start_s1;

	// decode state
	phase_t             phase_q;
	logic [LEN_W-1:0]   skip_q;
	logic [IMM_W-1:0]   pend_q;
	logic [BYTE_W-1:0]  modrm_q;
	logic [LEN_W-1:0]   cur_q;
	logic [TOTAL_W-1:0] total_q;
	logic               fin_q;

	// result register
	logic               out_valid_q;
	logic [LEN_W-1:0]   out_len_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic               out_complete_q;
	logic               out_unsup_q;

	// handshake: the decode stage moves whenever the result register can take a word
	logic adv;
	assign adv        = !out_valid_q || result.ready;
	assign code.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_cover_q <= MIN_COVER_RST;
		end else if (cfg_we) begin
			min_cover_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code.ready) begin
			valid_s1 <= code.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code.ready && code.valid) begin
			byte_s1  <= code.code_byte;
			start_s1 <= code.scan_start;
		end
	end

	// effective state: scan_start wipes everything before the byte is decoded
	phase_t             eff_phase;
	logic [LEN_W-1:0]   eff_skip;
	logic [IMM_W-1:0]   eff_pend;
	logic [BYTE_W-1:0]  eff_modrm;
	logic [LEN_W-1:0]   eff_cur;
	logic [TOTAL_W-1:0] eff_total;
	logic               eff_fin;

	always_comb begin
		if (start_s1) begin
			eff_phase = PH_OPC;
			eff_skip  = '0;
			eff_pend  = '0;
			eff_modrm = '0;
			eff_cur   = '0;
			eff_total = '0;
			eff_fin   = 1'b0;
		end else begin
			eff_phase = phase_q;
			eff_skip  = skip_q;
			eff_pend  = pend_q;
			eff_modrm = modrm_q;
			eff_cur   = cur_q;
			eff_total = total_q;
			eff_fin   = fin_q;
		end
	end

	// next state and result word
	phase_t             phase_n;
	logic [LEN_W-1:0]   skip_n;
	logic [IMM_W-1:0]   pend_n;
	logic [BYTE_W-1:0]  modrm_n;
	logic [LEN_W-1:0]   cur_n;
	logic [TOTAL_W-1:0] total_n;
	logic               fin_n;

	logic               res_valid;
	logic [LEN_W-1:0]   res_len;
	logic [TOTAL_W-1:0] res_total;
	logic               res_complete;
	logic               res_unsup;

	logic               do_fail;
	logic               do_done;
	logic               do_exp;
	logic [LEN_W-1:0]   exp_n;
	logic [LEN_W:0]     len_inc;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] sum_sat;
	logic               complete;
	logic [1:0]         mod;
	logic [2:0]         rm;
	logic [LEN_W-1:0]   pend_w;
	opc_info_t          info;

	always_comb begin
		phase_n = eff_phase;
		skip_n  = eff_skip;
		pend_n  = eff_pend;
		modrm_n = eff_modrm;
		cur_n   = eff_cur;
		total_n = eff_total;
		fin_n   = eff_fin;

		do_fail = 1'b0;
		do_done = 1'b0;
		do_exp  = 1'b0;
		exp_n   = '0;
		mod     = byte_s1[7:6];
		rm      = byte_s1[2:0];
		pend_w  = {1'b0, eff_pend};
		info    = classify(byte_s1);
		len_inc = {1'b0, eff_cur} + {{LEN_W{1'b0}}, 1'b1};

		res_valid    = 1'b0;
		res_len      = '0;
		res_total    = eff_total;
		res_complete = 1'b0;
		res_unsup    = 1'b0;

		// only bytes inside a live scan are decoded
		if (!eff_fin) begin
			if (len_inc > {1'b0, MAX_INSN_LEN}) begin
				// over-long instruction, also bounds a prefix run
				do_fail = 1'b1;
			end else begin
				cur_n = len_inc[LEN_W-1:0];
				unique case (eff_phase)
					PH_OP2: begin
						if (byte_s1 == OP2_SKIP1) begin
							do_exp = 1'b1;
							exp_n  = 4'd1;
						end else if (byte_s1 == OP2_MODRM) begin
							pend_n  = '0;
							phase_n = PH_MODRM;
						end else begin
							do_fail = 1'b1;
						end
					end
					PH_MODRM: begin
						modrm_n = byte_s1;
						if (mod == MOD_REG) begin
							do_exp = 1'b1;
							exp_n  = pend_w;
						end else if (rm == RM_SIB) begin
							phase_n = PH_SIB;
						end else if (mod == MOD_NODISP) begin
							do_exp = 1'b1;
							exp_n  = ((rm == RM_DISP32) ? 4'd4 : 4'd0) + pend_w;
						end else if (mod == MOD_DISP8) begin
							do_exp = 1'b1;
							exp_n  = 4'd1 + pend_w;
						end else begin
							do_exp = 1'b1;
							exp_n  = 4'd4 + pend_w;
						end
					end
					PH_SIB: begin
						// displacement size from the saved modrm, base from the sib byte
						do_exp = 1'b1;
						if (eff_modrm[7:6] == MOD_NODISP) begin
							exp_n = ((rm == RM_DISP32) ? 4'd4 : 4'd0) + pend_w;
						end else if (eff_modrm[7:6] == MOD_DISP8) begin
							exp_n = 4'd1 + pend_w;
						end else begin
							exp_n = 4'd4 + pend_w;
						end
					end
					PH_SKIP: begin
						if (eff_skip <= 4'd1) begin
							do_done = 1'b1;
						end else begin
							skip_n = eff_skip - 4'd1;
						end
					end
					PH_OPC: begin
						if (!is_prefix(byte_s1)) begin
							unique case (info.cls)
								OC_DONE: do_done = 1'b1;
								OC_IMM: begin
									do_exp = 1'b1;
									exp_n  = {1'b0, info.imm};
								end
								OC_MODRM: begin
									pend_n  = info.imm;
									phase_n = PH_MODRM;
								end
								OC_ESC:  phase_n = PH_OP2;
								default: do_fail = 1'b1;
							endcase
						end
					end
					default: do_fail = 1'b1;
				endcase

				// trailing displacement / immediate bytes, or end right here
				if (do_exp) begin
					if (exp_n == '0) begin
						do_done = 1'b1;
					end else begin
						skip_n  = exp_n;
						phase_n = PH_SKIP;
					end
				end
			end
		end

		sum      = {1'b0, eff_total} + {2'b00, cur_n};
		sum_sat  = (sum > {1'b0, TOTAL_SAT}) ? TOTAL_SAT : sum[TOTAL_W-1:0];
		complete = sum_sat >= {1'b0, min_cover_q};

		if (do_fail || do_done) begin
			phase_n = PH_OPC;
			skip_n  = '0;
			pend_n  = '0;
			modrm_n = '0;
			res_valid = 1'b1;
			if (do_fail) begin
				res_unsup = 1'b1;
				fin_n     = 1'b1;
			end else begin
				res_len      = cur_n;
				res_total    = sum_sat;
				res_complete = complete;
				total_n      = sum_sat;
				fin_n        = complete;
			end
			cur_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPC;
			skip_q  <= '0;
			pend_q  <= '0;
			modrm_q <= '0;
			cur_q   <= '0;
			total_q <= '0;
			fin_q   <= 1'b1;
		end else if (adv && valid_s1) begin
			phase_q <= phase_n;
			skip_q  <= skip_n;
			pend_q  <= pend_n;
			modrm_q <= modrm_n;
			cur_q   <= cur_n;
			total_q <= total_n;
			fin_q   <= fin_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && res_valid) begin
			out_len_q      <= res_len;
			out_total_q    <= res_total;
			out_complete_q <= res_complete;
			out_unsup_q    <= res_unsup;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.insn_length   = out_len_q;
	assign result.total_length  = out_total_q;
	assign result.scan_complete = out_complete_q;
	assign result.unsupported   = out_unsup_q;

	// an unsupported word carries no length and never completes the scan
	`XILD_ASSERT_IMP(a_unsup_word, out_valid_q && out_unsup_q,
		out_len_q == '0 && !out_complete_q, "unsupported word with length or complete")
	// every finished instruction has at least one byte
	`XILD_ASSERT_IMP(a_len_nonzero, out_valid_q && !out_unsup_q,
		out_len_q != '0, "finished instruction of zero length")
	// a scan-ending word leaves the decoder waiting for scan_start
	`XILD_ASSERT_NXT(a_scan_end, adv && valid_s1 && res_valid && (res_unsup || res_complete),
		fin_q, "scan not closed after its last word")
	// skip phase always has bytes left to skip
	`XILD_ASSERT_IMP(a_skip_count, phase_q == PH_SKIP,
		skip_q != '0, "skip phase with empty count")
	// the instruction length counter stays within the limit
	`XILD_ASSERT_IMP(a_len_bound, 1'b1,
		cur_q <= MAX_INSN_LEN, "instruction length counter past limit")

endmodule

`default_nettype wire
